@@ hdl/tcce_pkg.sv @@
// Shared types, codes and defaults for the text console cursor engine.
package tcce_pkg;

  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STOP = 8;

  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_RETURN   = 8'd13;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h07;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic sweep;
    logic init_mode;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

@@ hdl/tcce_ctrl.sv @@
// Controller state machine: sequences accept, execute, blanking sweeps and result load.
module tcce_ctrl
  import tcce_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        cmd.init_mode = 1'b1;
        if (st.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = st.need_sweep ? S_SWEEP : S_FINISH;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (st.sweep_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over an unaccepted beat");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> (state == S_EXEC))
    else $error("accepted item not executed next cycle");

endmodule

@@ hdl/tcce_dp.sv @@
// Datapath: screen memory, cursor, scroll row offset, blanking sweep and result register.
module tcce_dp
  import tcce_pkg::*;
#(
  parameter int COLUMNS  = DEF_COLUMNS,
  parameter int ROWS     = DEF_ROWS,
  parameter int TAB_STOP = DEF_TAB_STOP,
  localparam int CW = $clog2(COLUMNS),
  localparam int RW = $clog2(ROWS)
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output status_t       st,
  input  logic [1:0]    opcode,
  input  logic [7:0]    char_code,
  input  logic [RW-1:0] read_row,
  input  logic [CW-1:0] read_col,
  input  logic          cfg_valid,
  input  logic [7:0]    text_color,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [RW-1:0] cursor_row,
  output logic [CW-1:0] cursor_col,
  output logic [7:0]    cell_char,
  output logic [7:0]    cell_color,
  output logic          scrolled
);

  localparam int PW    = $clog2(TAB_STOP);
  localparam int TW    = $clog2(COLUMNS + TAB_STOP);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);

  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [PW-1:0] PH_LAST  = PW'(TAB_STOP - 1);
  localparam logic [PW-1:0] PH_EOL   = PW'((COLUMNS - 1) % TAB_STOP);

  // logical row to physical row under the scroll offset
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r, input logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (s >= (RW + 1)'(ROWS)) s = s - (RW + 1)'(ROWS);
    return s[RW-1:0];
  endfunction

  logic [15:0] mem [DEPTH];

  op_t           op_q;
  logic [7:0]    ch_q;
  logic [RW-1:0] rr_q;
  logic [CW-1:0] rc_q;

  logic [RW-1:0] row, row_next, base, base_next;
  logic [CW-1:0] col, col_next;
  logic [PW-1:0] phase, phase_next;
  logic [7:0]    color;
  logic          scr, scr_next, rd_ok, rd_ok_next;
  logic [RW-1:0] sw_row, sw_end, sw_start_row;
  logic [CW-1:0] sw_col;
  logic          start_sweep, nl;
  logic [15:0]   rdata;

  logic          ex_we, ren, we;
  logic [AW-1:0] ex_addr, raddr, waddr;
  logic [15:0]   ex_data, wdata, blank;
  logic [TW-1:0] tab_col;

  assign blank = {color, CH_SPACE};
  assign tab_col = TW'(col) + TW'(TAB_STOP) - TW'(phase);

  always_comb begin
    row_next = row;
    col_next = col;
    phase_next = phase;
    base_next = base;
    scr_next = 1'b0;
    rd_ok_next = 1'b0;
    ex_we = 1'b0;
    ex_addr = '0;
    ex_data = blank;
    ren = 1'b0;
    raddr = '0;
    start_sweep = 1'b0;
    sw_start_row = '0;
    nl = 1'b0;
    case (op_q)
      OP_PUT: begin
        if (ch_q == CH_NEWLINE) begin
          nl = 1'b1;
        end else if (ch_q == CH_RETURN) begin
          col_next = '0;
          phase_next = '0;
        end else if (ch_q == CH_TAB) begin
          if (tab_col >= TW'(COLUMNS)) begin
            nl = 1'b1;
          end else begin
            col_next = tab_col[CW-1:0];
            phase_next = '0;
          end
        end else begin
          ex_we = 1'b1;
          ex_addr = {phys_row(row, base), col};
          ex_data = {color, ch_q};
          if (col == COL_LAST) begin
            nl = 1'b1;
          end else begin
            col_next = col + 1'b1;
            phase_next = (phase == PH_LAST) ? '0 : phase + 1'b1;
          end
        end
      end
      OP_BACKSPACE: begin
        if (col != '0) begin
          col_next = col - 1'b1;
          phase_next = (phase == '0) ? PH_LAST : phase - 1'b1;
          ex_we = 1'b1;
          ex_addr = {phys_row(row, base), col - 1'b1};
        end else if (row != '0) begin
          row_next = row - 1'b1;
          col_next = COL_LAST;
          phase_next = PH_EOL;
          ex_we = 1'b1;
          ex_addr = {phys_row(row - 1'b1, base), COL_LAST};
        end
      end
      OP_CLEAR: begin
        row_next = '0;
        col_next = '0;
        phase_next = '0;
        base_next = '0;
        start_sweep = 1'b1;
      end
      default: begin
        if ({1'b0, rr_q} < (RW + 1)'(ROWS) && {1'b0, rc_q} < (CW + 1)'(COLUMNS)) begin
          ren = 1'b1;
          raddr = {phys_row(rr_q, base), rc_q};
          rd_ok_next = 1'b1;
        end
      end
    endcase
    if (nl) begin
      col_next = '0;
      phase_next = '0;
      if (row == ROW_LAST) begin
        // scroll: old top row becomes the new bottom row, blank it
        scr_next = 1'b1;
        base_next = (base == ROW_LAST) ? '0 : base + 1'b1;
        start_sweep = 1'b1;
        sw_start_row = base;
      end else begin
        row_next = row + 1'b1;
      end
    end
  end

  assign st.need_sweep = start_sweep;
  assign st.sweep_last = (sw_col == COL_LAST) && (sw_row == sw_end);
  assign st.out_free   = !out_valid || !out_stall;

  assign we    = (cmd.exec && ex_we) || cmd.sweep;
  assign waddr = cmd.sweep ? {sw_row, sw_col} : ex_addr;
  assign wdata = cmd.sweep ? (cmd.init_mode ? {RESET_COLOR, CH_SPACE} : blank) : ex_data;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.exec && ren) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q <= op_t'(opcode);
      ch_q <= char_code;
      rr_q <= read_row;
      rc_q <= read_col;
    end
    if (cmd.out_load) begin
      cursor_row <= row;
      cursor_col <= col;
      cell_char  <= rd_ok ? rdata[7:0] : 8'd0;
      cell_color <= rd_ok ? rdata[15:8] : 8'd0;
      scrolled   <= scr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      phase <= '0;
      base <= '0;
      scr <= 1'b0;
      rd_ok <= 1'b0;
      color <= RESET_COLOR;
      sw_row <= '0;
      sw_col <= '0;
      sw_end <= ROW_LAST;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) color <= text_color;
      if (cmd.exec) begin
        row <= row_next;
        col <= col_next;
        phase <= phase_next;
        base <= base_next;
        scr <= scr_next;
        rd_ok <= rd_ok_next;
        if (start_sweep) begin
          sw_row <= sw_start_row;
          sw_col <= '0;
          sw_end <= (op_q == OP_CLEAR) ? ROW_LAST : sw_start_row;
        end
      end
      if (cmd.sweep) begin
        // advance column, then row at the end of a line
        if (sw_col == COL_LAST) begin
          sw_col <= '0;
          if (sw_row != sw_end) sw_row <= sw_row + 1'b1;
        end else begin
          sw_col <= sw_col + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_phase_at_line_start: assert property (@(posedge clk) disable iff (rst)
    (col == '0) |-> (phase == '0))
    else $error("tab phase out of step with cursor column");

  a_scroll_homes_bottom: assert property (@(posedge clk) disable iff (rst)
    scr |-> (row == ROW_LAST && col == '0))
    else $error("scroll left cursor off the bottom line start");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    (base < ROW_LAST) || (base == ROW_LAST))
    else $error("row offset out of range");

  a_no_exec_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> !cmd.exec)
    else $error("write port claimed by sweep and execute at once");

endmodule

@@ hdl/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine: controller plus datapath.
//
// Input channel (in_valid/in_stall) carries one operation per beat: opcode,
// char_code, read_row, read_col. Output channel (out_valid/out_stall) returns
// one result beat per item: cursor position, read cell and scrolled flag.
// Config channel (cfg_valid/cfg_ready) writes text_color; cfg_ready is always
// high and writes belong to idle periods.
// Sequence: an item is taken in S_IDLE and executed in S_EXEC the next cycle;
// any blanking sweep then runs, and the result is loaded into the output
// register in S_FINISH once that register is free. A scroll blanks one row
// and a clear blanks the whole screen: the single write port of the
// screen memory blanks one cell a cycle. Scrolling moves a row offset rather
// than copying rows.
// After reset the screen memory is blanked to light-grey spaces in one sweep
// over every cell; in_stall stays high until it ends.
// A finished result waits in the output register while out_stall is high; the
// next item is still taken, and its result waits until that beat is taken.
module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int COLUMNS  = DEF_COLUMNS,
  parameter int ROWS     = DEF_ROWS,
  parameter int TAB_STOP = DEF_TAB_STOP,
  localparam int CW = $clog2(COLUMNS),
  localparam int RW = $clog2(ROWS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    opcode,
  input  logic [7:0]    char_code,
  input  logic [RW-1:0] read_row,
  input  logic [CW-1:0] read_col,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [RW-1:0] cursor_row,
  output logic [CW-1:0] cursor_col,
  output logic [7:0]    cell_char,
  output logic [7:0]    cell_color,
  output logic          scrolled,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    text_color
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  tcce_dp #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .opcode     (opcode),
    .char_code  (char_code),
    .read_row   (read_row),
    .read_col   (read_col),
    .cfg_valid  (cfg_valid && cfg_ready),
    .text_color (text_color),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .cell_char  (cell_char),
    .cell_color (cell_color),
    .scrolled   (scrolled)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the text console cursor engine.
`timescale 1ns / 1ps

module testbench;
  import tcce_pkg::*;

  localparam int COLUMNS     = DEF_COLUMNS;
  localparam int ROWS        = DEF_ROWS;
  localparam int TAB_STOP    = DEF_TAB_STOP;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int SEG_ITEMS   = 284;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] glyph;
    logic [7:0] attr;
    logic       scr;
  } console_result_t;

  typedef struct packed {
    op_t             op;
    logic [7:0]      ch;
    logic [4:0]      rr;
    logic [6:0]      rc;
    logic [11:0]     reps;
    logic            pinned;
    console_result_t res;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [7:0] char_code = '0;
  logic [4:0] read_row = '0;
  logic [6:0] read_col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic [7:0] cell_char;
  logic [7:0] cell_color;
  logic scrolled;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] text_color = RESET_COLOR;

  // typed-in expectation travels with its beat
  logic pin_valid = 1'b0;
  console_result_t pin_result = '0;

  // predictor state
  logic [15:0] screen_img [ROWS*COLUMNS];
  int cur_row;
  int cur_col;
  logic [7:0] attr_reg;

  console_result_t pending_results[$];
  int items_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 25;
  int recv_idle_pct = 25;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  text_console_cursor_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col),
    .cell_char (cell_char),
    .cell_color(cell_color),
    .scrolled  (scrolled),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .text_color(text_color)
  );

  always #1 clk = ~clk;

  task automatic log_mismatch(input string what, input int got, input int want_v);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want_v, cycle_count);
    mismatch_count++;
  endtask

  // Move to the start of the next line, scrolling at the bottom.
  function automatic logic advance_line();
    cur_col = 0;
    if (cur_row == ROWS - 1) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_img[i] = screen_img[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++)
        screen_img[i] = {attr_reg, CH_SPACE};
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic console_result_t apply_console_op(input op_t op, input logic [7:0] ch,
                                                       input logic [4:0] rr,
                                                       input logic [6:0] rc);
    console_result_t res;
    logic [15:0] cell_word;
    res = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_NEWLINE) res.scr = advance_line();
        else if (ch == CH_RETURN) cur_col = 0;
        else if (ch == CH_TAB) begin
          cur_col = cur_col + TAB_STOP - cur_col % TAB_STOP;
          if (cur_col >= COLUMNS) res.scr = advance_line();
        end else begin
          screen_img[cur_row * COLUMNS + cur_col] = {attr_reg, ch};
          cur_col++;
          if (cur_col >= COLUMNS) res.scr = advance_line();
        end
      end
      OP_BACKSPACE: begin
        if (cur_col > 0 || cur_row > 0) begin
          if (cur_col > 0) cur_col--;
          else begin
            cur_row--;
            cur_col = COLUMNS - 1;
          end
          screen_img[cur_row * COLUMNS + cur_col] = {attr_reg, CH_SPACE};
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < ROWS * COLUMNS; i++) screen_img[i] = {attr_reg, CH_SPACE};
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        if (rr < ROWS && rc < COLUMNS) begin
          cell_word = screen_img[rr * COLUMNS + rc];
          res.glyph = cell_word[7:0];
          res.attr = cell_word[15:8];
        end
      end
    endcase
    res.row = cur_row[4:0];
    res.col = cur_col[6:0];
    return res;
  endfunction

  // Predict on accepted input beats, check accepted output beats.
  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      for (int i = 0; i < ROWS * COLUMNS; i++) screen_img[i] = {RESET_COLOR, CH_SPACE};
      cur_row = 0;
      cur_col = 0;
      attr_reg = RESET_COLOR;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          log_mismatch("unexpected result beat, row", int'(cursor_row), 0);
        end else begin
          want = pending_results.pop_front();
          if (cursor_row !== want.row)
            log_mismatch("cursor_row", int'(cursor_row), int'(want.row));
          if (cursor_col !== want.col)
            log_mismatch("cursor_col", int'(cursor_col), int'(want.col));
          if (cell_char !== want.glyph)
            log_mismatch("cell_char", int'(cell_char), int'(want.glyph));
          if (cell_color !== want.attr)
            log_mismatch("cell_color", int'(cell_color), int'(want.attr));
          if (scrolled !== want.scr)
            log_mismatch("scrolled", int'(scrolled), int'(want.scr));
        end
      end
      if (cfg_valid && cfg_ready) attr_reg = text_color;
      if (in_valid && !in_stall) begin
        want = apply_console_op(op_t'(opcode), char_code, read_row, read_col);
        if (pin_valid) want = pin_result;
        pending_results.push_back(want);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic offer(input op_t op, input logic [7:0] ch, input logic [4:0] rr,
                       input logic [6:0] rc, input logic pinned, input console_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    char_code <= ch;
    read_row <= rr;
    read_col <= rc;
    pin_valid <= pinned;
    pin_result <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_for_results();
    while (results_seen < items_sent) @(posedge clk);
  endtask

  function automatic step_row_t mk_row(input op_t op, input logic [7:0] ch,
                                       input logic [4:0] rr, input logic [6:0] rc,
                                       input int reps, input logic pinned,
                                       input console_result_t res);
    step_row_t s;
    s.op = op;
    s.ch = ch;
    s.rr = rr;
    s.rc = rc;
    s.reps = reps[11:0];
    s.pinned = pinned;
    s.res = res;
    return s;
  endfunction

  initial begin
    step_row_t plan[$];
    console_result_t reset_cell;
    console_result_t empty_res;
    op_t op;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    int pick;
    int sel;

    reset_cell = {5'd0, 7'd0, CH_SPACE, RESET_COLOR, 1'b0};
    empty_res = '0;

    plan.push_back(mk_row(OP_READ, 8'h00, 5'd0, 7'd0, 1, 1'b1, reset_cell));
    plan.push_back(mk_row(OP_READ, 8'hFF, 5'd24, 7'd79, 1, 1'b1, reset_cell));
    plan.push_back(mk_row(OP_READ, 8'h00, 5'd31, 7'd127, 1, 1'b1, empty_res));
    plan.push_back(mk_row(OP_READ, 8'h00, 5'd25, 7'd0, 1, 1'b1, empty_res));
    plan.push_back(mk_row(OP_READ, 8'h00, 5'd0, 7'd80, 1, 1'b1, empty_res));
    plan.push_back(mk_row(OP_BACKSPACE, 8'h00, 5'd0, 7'd0, 1, 1'b1, empty_res));
    plan.push_back(mk_row(OP_PUT, 8'h41, 5'd31, 7'd127, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_PUT, 8'hFF, 5'd0, 7'd0, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_PUT, 8'h00, 5'd0, 7'd0, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_READ, 8'h00, 5'd0, 7'd1, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_PUT, CH_TAB, 5'd0, 7'd0, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_PUT, CH_RETURN, 5'd0, 7'd0, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_PUT, CH_NEWLINE, 5'd0, 7'd0, 1, 1'b0, empty_res));
    // backspace from a line start wraps to the last column above
    plan.push_back(mk_row(OP_BACKSPACE, 8'h00, 5'd0, 7'd0, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_PUT, 8'h5A, 5'd0, 7'd0, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_PUT, CH_NEWLINE, 5'd0, 7'd0, 23, 1'b0, empty_res));
    plan.push_back(mk_row(OP_PUT, CH_NEWLINE, 5'd0, 7'd0, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_PUT, 8'h23, 5'd0, 7'd0, 75, 1'b0, empty_res));
    // tab past the last stop on the bottom row scrolls
    plan.push_back(mk_row(OP_PUT, CH_TAB, 5'd0, 7'd0, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_PUT, 8'h77, 5'd0, 7'd0, 80, 1'b0, empty_res));
    plan.push_back(mk_row(OP_READ, 8'h00, 5'd23, 7'd0, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_READ, 8'h00, 5'd24, 7'd0, 1, 1'b0, empty_res));
    plan.push_back(mk_row(OP_CLEAR, 8'h00, 5'd0, 7'd0, 1, 1'b1, empty_res));
    plan.push_back(mk_row(OP_READ, 8'h00, 5'd12, 7'd40, 1, 1'b1, reset_cell));
    plan.push_back(mk_row(OP_BACKSPACE, 8'h00, 5'd0, 7'd0, 1, 1'b1, empty_res));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++)
        offer(plan[i].op, plan[i].ch, plan[i].rr, plan[i].rc, plan[i].pinned, plan[i].res);
    end

    for (int seg = 0; seg < 6; seg++) begin
      // drain, let the block settle, then change the color
      in_valid <= 1'b0;
      wait_for_results();
      repeat (8) @(posedge clk);
      cfg_valid <= 1'b1;
      if (seg == 0) text_color <= 8'h00;
      else if (seg == 1) text_color <= 8'hFF;
      else text_color <= 8'($urandom_range(255));
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_valid <= 1'b0;
      send_idle_pct = (seg < 2) ? 38 : (seg < 4) ? 63 : 0;
      recv_idle_pct = (seg < 2) ? 63 : (seg < 4) ? 38 : 0;
      if (seg == 0 || seg == 4) hold_tog <= ~hold_tog;

      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (seg == 2 && n == SEG_ITEMS / 2) begin
          in_valid <= 1'b0;
          wait_for_results();
        end
        // unused fields carry noise
        ch = 8'($urandom_range(255));
        rr = 5'($urandom_range(31));
        rc = 7'($urandom_range(127));
        pick = $urandom_range(999);
        if (pick < 5) begin
          op = OP_CLEAR;
        end else if (pick < 150) begin
          op = OP_BACKSPACE;
        end else if (pick < 350) begin
          op = OP_READ;
          if ($urandom_range(99) < 85) begin
            rr = 5'($urandom_range(ROWS - 1));
            rc = 7'($urandom_range(COLUMNS - 1));
          end
        end else begin
          op = OP_PUT;
          sel = $urandom_range(99);
          if (sel < 10) ch = CH_NEWLINE;
          else if (sel < 15) ch = CH_TAB;
          else if (sel < 19) ch = CH_RETURN;
          else if (sel < 85) ch = 8'($urandom_range(126, 32));
        end
        offer(op, ch, rr, rc, 1'b0, empty_res);
      end
    end

    in_valid <= 1'b0;
    wait_for_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      log_mismatch("results never returned", 0, pending_results.size());
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
